/* hw/rtl/tpc_pkg.sv */
// ----------------------------------------------------------------------------
// tpc_pkg: shared types and constants for the test packet checker
// Item structs for both channels, register indexes, reset marks and
// the field masks of the packet layout.
// ----------------------------------------------------------------------------
`default_nettype none

package tpc_pkg;

    localparam int COUNT_DIGITS_DEF = 8;
    localparam int DATA_DIGITS_DEF  = 8;

    localparam logic [7:0] TAG_MASK   = 8'hC0;
    localparam logic [7:0] TAG_VALUE  = 8'h40;
    localparam logic [7:0] DATA_LIMIT = 8'h40;
    localparam logic [7:0] DIGIT_MASK = 8'h3F;

    localparam int         POS_W   = 5;
    localparam logic [4:0] POS_MAX = 5'd31;

    localparam int CFG_INDEX_W = 8;

    localparam logic [7:0] REG_START_MARK        = 8'd0;
    localparam logic [7:0] REG_END_MARK          = 8'd1;
    localparam logic [7:0] REG_ANSWER_START_MARK = 8'd2;
    localparam logic [7:0] REG_ANSWER_END_MARK   = 8'd3;

    localparam logic [7:0] START_MARK_RST        = 8'd2;
    localparam logic [7:0] END_MARK_RST          = 8'd3;
    localparam logic [7:0] ANSWER_START_MARK_RST = 8'd4;
    localparam logic [7:0] ANSWER_END_MARK_RST   = 8'd5;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } tpc_in_t;

    typedef struct packed {
        logic [47:0] packet_count;
        logic        packet_valid;
        logic        is_answer;
    } tpc_out_t;

endpackage

`default_nettype wire

/* hw/rtl/test_packet_checker_unit.sv */
// ----------------------------------------------------------------------------
// test_packet_checker_unit: link test packet checker
// Checks marks, counter tags, data range, length and checksum of a packet
// received one byte per item, and reports the verdict on its last byte.
// ----------------------------------------------------------------------------
//  channel | signals                               | direction
//  --------+---------------------------------------+----------
//  in      | in_valid, in_ready, in_data           | input item
//  out     | out_valid, out_ready, out_data        | result item
//  cfg     | cfg_valid, cfg_ready, cfg_index/data  | register write
//
//  One byte per cycle while in_ready is high; a result appears in the output
//  register in the cycle after its last byte is taken. All per-byte checks are a
//  compare and a 9-bit accumulate between the packet state and the result register.
//  Reset clears packet state, the output register and loads the reset marks.
//  in_ready drops only while a result is held and out_ready is low.
//  cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module test_packet_checker_unit
    import tpc_pkg::*;
#(
    parameter int COUNT_DIGITS = COUNT_DIGITS_DEF,
    parameter int DATA_DIGITS  = DATA_DIGITS_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire tpc_in_t                in_data,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output tpc_out_t                    out_data,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [7:0]             cfg_data
);

    localparam logic [POS_W-1:0] POS_DATA  = POS_W'(1 + COUNT_DIGITS);
    localparam logic [POS_W-1:0] POS_CHECK = POS_W'(1 + COUNT_DIGITS + DATA_DIGITS);
    localparam logic [POS_W-1:0] POS_CHK_LO = POS_W'(2 + COUNT_DIGITS + DATA_DIGITS);
    localparam logic [POS_W-1:0] POS_END   = POS_W'(3 + COUNT_DIGITS + DATA_DIGITS);

    logic [7:0]       start_mark_reg;
    logic [7:0]       end_mark_reg;
    logic [7:0]       answer_start_mark_reg;
    logic [7:0]       answer_end_mark_reg;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [47:0]      count_reg, count_next;
    logic [8:0]       sum_reg, sum_next;
    logic [5:0]       chk_high_reg, chk_high_next;
    logic             error_reg, error_next;
    logic [7:0]       first_reg, first_next;

    logic             out_valid_reg;
    tpc_out_t         out_reg, out_next;

    logic             in_fire;
    logic [7:0]       b;
    logic             normal;
    logic             answer;
    logic             valid;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign b         = in_data.data_byte;

    always_comb
    begin
        pos_next      = pos_reg;
        count_next    = count_reg;
        sum_next      = sum_reg;
        chk_high_next = chk_high_reg;
        error_next    = error_reg;
        first_next    = first_reg;

        if (pos_reg == '0)
        begin
            first_next = b;
        end
        else if (pos_reg < POS_DATA)
        begin
            if ((b & TAG_MASK) != TAG_VALUE)
                error_next = 1'b1;
            count_next = {count_reg[41:0], b[5:0]};
        end
        else if (pos_reg < POS_CHECK)
        begin
            if (b >= DATA_LIMIT)
                error_next = 1'b1;
            else
                sum_next = sum_reg + {1'b0, b};
        end
        else if (pos_reg == POS_CHECK)
        begin
            chk_high_next = b[5:0];
        end
        else if (pos_reg == POS_CHK_LO)
        begin
            if ({chk_high_reg, b[5:0]} != {3'b000, sum_reg})
                error_next = 1'b1;
        end
        else if (pos_reg != POS_END)
        begin
            error_next = 1'b1;
        end

        if (pos_reg < POS_MAX)
            pos_next = pos_reg + 1'b1;

        normal = (first_next == start_mark_reg) && (b == end_mark_reg);
        answer = (first_next == answer_start_mark_reg) && (b == answer_end_mark_reg);
        valid  = !error_next && (pos_reg == POS_END) && (normal || answer);

        out_next.packet_count = valid ? count_next : '0;
        out_next.packet_valid = valid;
        out_next.is_answer    = valid && !normal && answer;

        // drop all packet state once the verdict is out
        if (in_data.last_byte)
        begin
            pos_next      = '0;
            count_next    = '0;
            sum_next      = '0;
            chk_high_next = '0;
            error_next    = 1'b0;
            first_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            count_reg    <= '0;
            sum_reg      <= '0;
            chk_high_reg <= '0;
            error_reg    <= 1'b0;
            first_reg    <= '0;
        end
        else if (in_fire)
        begin
            pos_reg      <= pos_next;
            count_reg    <= count_next;
            sum_reg      <= sum_next;
            chk_high_reg <= chk_high_next;
            error_reg    <= error_next;
            first_reg    <= first_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_fire && in_data.last_byte)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_reg <= '0;
        else if (in_fire && in_data.last_byte)
            out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_mark_reg        <= START_MARK_RST;
            end_mark_reg          <= END_MARK_RST;
            answer_start_mark_reg <= ANSWER_START_MARK_RST;
            answer_end_mark_reg   <= ANSWER_END_MARK_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_START_MARK:        start_mark_reg        <= cfg_data;
                REG_END_MARK:          end_mark_reg          <= cfg_data;
                REG_ANSWER_START_MARK: answer_start_mark_reg <= cfg_data;
                REG_ANSWER_END_MARK:   answer_end_mark_reg   <= cfg_data;
                default:               ;
            endcase
        end
    end

    a_answer_implies_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.is_answer |-> out_data.packet_valid)
        else $error("answer flag set on an invalid packet");

    a_invalid_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.packet_valid |-> out_data.packet_count == '0)
        else $error("invalid packet carries a nonzero count");

    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && in_data.last_byte |=> out_valid)
        else $error("last byte did not produce a result");

    a_last_clears_pos: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && in_data.last_byte |=> pos_reg == '0 && !error_reg)
        else $error("packet state not cleared after last byte");

endmodule

`default_nettype wire

/* tb/sv/tb_test_packet_checker_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_test_packet_checker_unit: self-checking bench for the test packet checker
// Feeds packets one byte per item through the valid/ready input channel: a
// short table of fixed packets, then random packets (mostly well formed, some
// corrupted, some noise) under three mark settings and three idling patterns.
// A local packet decoder predicts each random verdict, the table states its own;
// the result channel is checked field by field against the queue of pending verdicts.
// ----------------------------------------------------------------------------

module tb_test_packet_checker_unit;
    import tpc_pkg::*;

    localparam int DATA_AT  = 1 + COUNT_DIGITS_DEF;
    localparam int CHECK_AT = DATA_AT + DATA_DIGITS_DEF;
    localparam int END_AT   = CHECK_AT + 2;
    localparam int PKT_LEN  = END_AT + 1;

    localparam tpc_out_t NO_PACKET = '0;

    typedef struct {
        tpc_in_t  item;
        bit       typed;
        tpc_out_t verdict;
    } table_row_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_ready;
    tpc_in_t                in_data   = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    tpc_out_t               out_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [7:0]             cfg_data  = '0;

    // packet decoder state and its copy of the marks
    logic [7:0]  mark_start     = START_MARK_RST;
    logic [7:0]  mark_end       = END_MARK_RST;
    logic [7:0]  mark_ans_start = ANSWER_START_MARK_RST;
    logic [7:0]  mark_ans_end   = ANSWER_END_MARK_RST;
    logic [4:0]  byte_pos       = '0;
    logic [47:0] count_acc      = '0;
    logic [8:0]  data_total     = '0;
    logic [5:0]  ck_high        = '0;
    logic        bad            = 1'b0;
    logic [7:0]  first_seen     = '0;

    tpc_out_t   pending_verdicts[$];
    table_row_t directed_rows[$];
    int         mismatches    = 0;
    int         items_sent    = 0;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;

    test_packet_checker_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("tb_test_packet_checker_unit: FAIL");
        $finish;
    end

    // Advance the decoder by one byte; returns 1 when the byte ends a packet.
    function automatic bit predict_byte(input tpc_in_t item, output tpc_out_t verdict);
        logic [7:0] b;
        logic       normal;
        logic       answer;
        logic       ok;
        b       = item.data_byte;
        verdict = NO_PACKET;
        if (byte_pos == 0)
            first_seen = b;
        else if (byte_pos < DATA_AT)
        begin
            if ((b & TAG_MASK) != TAG_VALUE)
                bad = 1'b1;
            count_acc = {count_acc[41:0], b[5:0]};
        end
        else if (byte_pos < CHECK_AT)
        begin
            if (b >= DATA_LIMIT)
                bad = 1'b1;
            else
                data_total = data_total + b;
        end
        else if (byte_pos == CHECK_AT)
            ck_high = b[5:0];
        else if (byte_pos == CHECK_AT + 1)
        begin
            if ({ck_high, b[5:0]} != data_total)
                bad = 1'b1;
        end
        else if (byte_pos != END_AT)
            bad = 1'b1;

        if (!item.last_byte)
        begin
            if (byte_pos != POS_MAX)
                byte_pos = byte_pos + 1'b1;
            return 1'b0;
        end

        normal = (first_seen == mark_start) && (b == mark_end);
        answer = (first_seen == mark_ans_start) && (b == mark_ans_end);
        ok     = !bad && (byte_pos == END_AT) && (normal || answer);
        verdict.packet_count = ok ? count_acc : 48'd0;
        verdict.packet_valid = ok;
        verdict.is_answer    = ok && !normal && answer;

        byte_pos   = '0;
        count_acc  = '0;
        data_total = '0;
        ck_high    = '0;
        bad        = 1'b0;
        first_seen = '0;
        return 1'b1;
    endfunction

    function automatic void add_row(input logic [7:0] d, input bit last, input bit typed = 0,
                                    input tpc_out_t verdict = NO_PACKET);
        table_row_t row;
        row.item.data_byte = d;
        row.item.last_byte = last;
        row.typed          = typed;
        row.verdict        = verdict;
        directed_rows.push_back(row);
    endfunction

    task automatic push_byte(input tpc_in_t item, input bit from_table,
                             input tpc_out_t table_verdict);
        tpc_out_t verdict;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (predict_byte(item, verdict))
            pending_verdicts.push_back(from_table ? table_verdict : verdict);
        items_sent++;
        @(negedge clk);
    endtask

    // Hold the input until every pending verdict has come out.
    task automatic settle();
        in_valid = 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_START_MARK:        mark_start     = value;
            REG_END_MARK:          mark_end       = value;
            REG_ANSWER_START_MARK: mark_ans_start = value;
            REG_ANSWER_END_MARK:   mark_ans_end   = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic send_random_packet();
        logic [7:0] body[$];
        logic [8:0] sum;
        logic [7:0] b;
        logic [7:0] tail;
        logic [1:0] top;
        int         pick;
        int         at;
        int         len;
        bit         as_answer;
        tpc_in_t    item;
        if ($urandom_range(19) == 0)
            settle();
        pick      = $urandom_range(99);
        as_answer = $urandom_range(1);
        sum       = '0;
        body.push_back(as_answer ? mark_ans_start : mark_start);
        repeat (COUNT_DIGITS_DEF)
            body.push_back({2'b01, 6'($urandom_range(63))});
        repeat (DATA_DIGITS_DEF)
        begin
            b = 8'($urandom_range(63));
            sum += b;
            body.push_back(b);
        end
        // top bits of the checksum digits are don't-care: randomize them
        body.push_back({2'($urandom_range(3)), 3'b000, sum[8:6]});
        body.push_back({2'($urandom_range(3)), sum[5:0]});
        body.push_back(as_answer ? mark_ans_end : mark_end);

        if (pick >= 58)
        begin
            case ((pick - 58) / 6)
                0:
                begin
                    top = 2'($urandom_range(2));
                    if (top == 2'b01)
                        top = 2'b11;
                    at = $urandom_range(1, DATA_AT - 1);
                    body[at] = {top, body[at][5:0]};
                end
                1:
                begin
                    at = $urandom_range(DATA_AT, CHECK_AT - 1);
                    body[at] = 8'($urandom_range(8'h40, 8'hFF));
                end
                2:
                begin
                    at = CHECK_AT + $urandom_range(1);
                    body[at] = body[at] ^ 8'(1 << $urandom_range(5));
                end
                3:
                begin
                    if ($urandom_range(1))
                        body[0] = 8'($urandom_range(255));
                    else
                        body[PKT_LEN - 1] = 8'($urandom_range(255));
                end
                4:
                begin
                    len = $urandom_range(1, PKT_LEN - 1);
                    while (body.size() > len)
                        void'(body.pop_back());
                end
                5:
                begin
                    // run past the end, at times far enough to saturate the position
                    tail = body.pop_back();
                    repeat ($urandom_range(1, 20))
                        body.push_back(8'($urandom_range(255)));
                    body.push_back(tail);
                end
                default:
                begin
                    body.delete();
                    repeat ($urandom_range(1, 40))
                        body.push_back(8'($urandom_range(255)));
                end
            endcase
        end

        foreach (body[i])
        begin
            item.data_byte = body[i];
            item.last_byte = (i == body.size() - 1);
            push_byte(item, 1'b0, NO_PACKET);
        end
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct, input int n_items);
        int first_item;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        first_item    = items_sent;
        while (items_sent - first_item < n_items)
            send_random_packet();
    endtask

    always @(negedge clk)
        out_ready = ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin : check_results
        tpc_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
                mismatches++;
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (out_data.packet_count !== want.packet_count)
                begin
                    $display("%0t: packet_count expected %h actual %h",
                             $time, want.packet_count, out_data.packet_count);
                    mismatches++;
                end
                if (out_data.packet_valid !== want.packet_valid)
                begin
                    $display("%0t: packet_valid expected %b actual %b",
                             $time, want.packet_valid, out_data.packet_valid);
                    mismatches++;
                end
                if (out_data.is_answer !== want.is_answer)
                begin
                    $display("%0t: is_answer expected %b actual %b",
                             $time, want.is_answer, out_data.is_answer);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin : stimulus
        tpc_out_t   full_count;
        logic [7:0] lead;
        logic [7:0] trail;
        full_count.packet_count = 48'hFFFF_FFFF_FFFF;
        full_count.packet_valid = 1'b1;
        full_count.is_answer    = 1'b0;

        // one-byte packets are always too short
        add_row(8'hFF, 1'b1, 1'b1, NO_PACKET);
        add_row(8'h00, 1'b1, 1'b1, NO_PACKET);
        // normal packet with every counter digit and data byte at its top value
        add_row(START_MARK_RST, 1'b0);
        repeat (COUNT_DIGITS_DEF)
            add_row(8'h7F, 1'b0);
        repeat (DATA_DIGITS_DEF)
            add_row(8'h3F, 1'b0);
        add_row(8'hC7, 1'b0);
        add_row(8'hF8, 1'b0);
        add_row(END_MARK_RST, 1'b1, 1'b1, full_count);
        // answer marks but only two bytes long
        add_row(ANSWER_START_MARK_RST, 1'b0);
        add_row(ANSWER_END_MARK_RST, 1'b1, 1'b1, NO_PACKET);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_idle_pct = 18;
        recv_idle_pct = 51;
        foreach (directed_rows[r])
            push_byte(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].verdict);
        settle();

        write_reg(REG_START_MARK, 8'h00);
        write_reg(REG_END_MARK, 8'hFF);
        write_reg(REG_ANSWER_START_MARK, 8'hFF);
        write_reg(REG_ANSWER_END_MARK, 8'h00);
        run_phase(18, 51, 500);
        settle();

        write_reg(REG_START_MARK, 8'($urandom_range(255)));
        write_reg(REG_END_MARK, 8'($urandom_range(255)));
        write_reg(REG_ANSWER_START_MARK, 8'($urandom_range(255)));
        write_reg(REG_ANSWER_END_MARK, 8'($urandom_range(255)));
        run_phase(51, 18, 500);
        settle();

        // both pairs equal: every good packet matches both and counts as normal
        lead  = 8'($urandom_range(255));
        trail = 8'($urandom_range(255));
        write_reg(REG_START_MARK, lead);
        write_reg(REG_END_MARK, trail);
        write_reg(REG_ANSWER_START_MARK, lead);
        write_reg(REG_ANSWER_END_MARK, trail);
        run_phase(0, 0, 500);

        in_valid = 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("tb_test_packet_checker_unit: PASS");
        else
            $display("tb_test_packet_checker_unit: FAIL");
        $finish;
    end

endmodule
